@@ hw/rtl/bhp_pkg.sv @@
// Shared types and constants of the biquad high-pass filter.
`default_nettype none

package bhp_pkg;

  // Coefficient register width and the Q3.28 fraction width.
  localparam int COEF_BITS = 32;
  localparam int FRAC_BITS = 28;
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = 32'sh1000_0000;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_B0  = 3'd0;
  localparam logic [2:0] REG_B1  = 3'd1;
  localparam logic [2:0] REG_B2  = 3'd2;
  localparam logic [2:0] REG_A1  = 3'd3;
  localparam logic [2:0] REG_A2  = 3'd4;
  localparam logic [2:0] REG_INV = 3'd5;

  // Multiplier operand selection, one code for each pass of the shared unit.
  localparam logic [2:0] SEL_B0  = 3'd0;
  localparam logic [2:0] SEL_B1  = 3'd1;
  localparam logic [2:0] SEL_B2  = 3'd2;
  localparam logic [2:0] SEL_A1  = 3'd3;
  localparam logic [2:0] SEL_A2  = 3'd4;
  localparam logic [2:0] SEL_INV = 3'd5;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
    logic signed [COEF_BITS-1:0] inv_a0;
  } bhp_coef_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;     // capture the input item and clear the accumulator
    logic       mul;      // register one product of the shared multiplier
    logic [2:0] mul_sel;  // operand pair for that product
    logic       acc_add;  // add the registered product to the accumulator
    logic       acc_sub;  // subtract it instead (feedback terms)
    logic       rnd;      // round the accumulator into the intermediate value
    logic       commit;   // load the result register and shift the delay line
  } bhp_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/bhp_regs.sv @@
// Configuration register file on the APB-style port.
`default_nettype none

module bhp_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output bhp_pkg::bhp_coef_t    coef
);
  import bhp_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0     <= COEF_ONE;
      coef.b1     <= '0;
      coef.b2     <= '0;
      coef.a1     <= '0;
      coef.a2     <= '0;
      coef.inv_a0 <= COEF_ONE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_B0:  coef.b0     <= pwdata;
        REG_B1:  coef.b1     <= pwdata;
        REG_B2:  coef.b2     <= pwdata;
        REG_A1:  coef.a1     <= pwdata;
        REG_A2:  coef.a2     <= pwdata;
        REG_INV: coef.inv_a0 <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_idx)
      REG_B0:  prdata = coef.b0;
      REG_B1:  prdata = coef.b1;
      REG_B2:  prdata = coef.b2;
      REG_A1:  prdata = coef.a1;
      REG_A2:  prdata = coef.a2;
      REG_INV: prdata = coef.inv_a0;
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/bhp_ctrl.sv @@
// Controller state machine that sequences the shared multiply-accumulate unit.
`default_nettype none

module bhp_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_ready,
  input  wire logic         out_free,
  output bhp_pkg::bhp_cmd_t cmd
);
  import bhp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_GAIN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] step;
  logic [2:0] step_next;
  logic [2:0] prev_sel;

  // The product accumulated in a step was selected in the step before.
  assign prev_sel = step - 3'd1;

  // Next state, step count and commands.
  always_comb begin
    state_next = state;
    step_next  = step;
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          step_next  = SEL_B0;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mul     = (step != SEL_INV);
        cmd.mul_sel = step;
        cmd.acc_add = (step != SEL_B0);
        cmd.acc_sub = (step != SEL_B0) && (prev_sel inside {SEL_A1, SEL_A2});
        step_next   = step + 3'd1;
        if (step == SEL_INV) begin
          state_next = S_RND;
        end
      end
      S_RND: begin
        cmd.rnd    = 1'b1;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = SEL_INV;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= SEL_B0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bhp_datapath.sv @@
// Datapath: shared multiplier, accumulator, rounding, saturation and delay state.
`default_nettype none

module bhp_datapath #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bhp_pkg::bhp_cmd_t             cmd,
  input  wire bhp_pkg::bhp_coef_t            coef,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic                          chan_sel,
  input  wire logic                          result_ready,
  output logic                               result_valid,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  output logic                               chan_out,
  output logic                               out_free
);
  import bhp_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MB_W   = SAMPLE_BITS + 7;        // second multiplier operand
  localparam int PROD_W = COEF_BITS + MB_W;       // registered product
  localparam int ACC_W  = SAMPLE_BITS + 35;       // five products without loss
  localparam int RND_W  = PROD_W - FRAC_BITS;     // rounded gain product
  localparam int TOP_W  = RND_W - SAMPLE_BITS + 1;

  localparam logic signed [ACC_W-1:0]  HALF_A = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x_cur;
  logic                          chan_cur;
  logic [CH_W-1:0]               ch;

  logic signed [SAMPLE_BITS-1:0] x1 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x2 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y1 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y2 [CHANNELS];

  logic signed [COEF_BITS-1:0] op_a;
  logic signed [MB_W-1:0]      op_b;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     acc_rnd;
  logic signed [MB_W-1:0]      mid;
  logic signed [PROD_W-1:0]    prod_rnd;
  logic signed [RND_W-1:0]     y_wide;
  logic [TOP_W-1:0]            y_top;
  logic [SAMPLE_BITS-1:0]      y_sat;

  // Channel of the current item; out-of-range codes fold onto channel zero.
  assign ch = (CHANNELS > 1) ? CH_W'(chan_cur) : '0;

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_cur    <= sample_in;
      chan_cur <= chan_sel;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_sel)
      SEL_B0: begin
        op_a = coef.b0;
        op_b = {{7{x_cur[SAMPLE_BITS-1]}}, x_cur};
      end
      SEL_B1: begin
        op_a = coef.b1;
        op_b = {{7{x1[ch][SAMPLE_BITS-1]}}, x1[ch]};
      end
      SEL_B2: begin
        op_a = coef.b2;
        op_b = {{7{x2[ch][SAMPLE_BITS-1]}}, x2[ch]};
      end
      SEL_A1: begin
        op_a = coef.a1;
        op_b = {{7{y1[ch][SAMPLE_BITS-1]}}, y1[ch]};
      end
      SEL_A2: begin
        op_a = coef.a2;
        op_b = {{7{y2[ch][SAMPLE_BITS-1]}}, y2[ch]};
      end
      SEL_INV: begin
        op_a = coef.inv_a0;
        op_b = mid;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Multiplier with its product register.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= op_a * op_b;
    end
  end

  // Accumulator; the feedback terms are subtracted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      if (cmd.acc_sub) begin
        acc <= acc - ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // First rounding: round half up from Q.51 to Q.23.
  assign acc_rnd = acc + HALF_A;

  always_ff @(posedge clk) begin
    if (cmd.rnd) begin
      mid <= acc_rnd[ACC_W-1:FRAC_BITS];
    end
  end

  // Second rounding after the gain, then saturation to the sample width.
  assign prod_rnd = prod + HALF_P;
  assign y_wide   = prod_rnd[PROD_W-1:FRAC_BITS];
  assign y_top    = y_wide[RND_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&y_top) || !(|y_top)) begin
      y_sat = y_wide[SAMPLE_BITS-1:0];
    end else if (y_wide[RND_W-1]) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = Y_MAX;
    end
  end

  // Result register, kept apart from the input side.
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sample_out <= y_sat;
      chan_out   <= chan_cur;
    end
  end

  // Per-channel delay state, shifted when a result is committed.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        x1[c] <= '0;
        x2[c] <= '0;
        y1[c] <= '0;
        y2[c] <= '0;
      end
    end else if (cmd.commit) begin
      x2[ch] <= x1[ch];
      x1[ch] <= x_cur;
      y2[ch] <= y1[ch];
      y1[ch] <= y_sat;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/biquad_high_pass_filter.sv @@
// Top level of the multi-channel Direct Form I biquad high-pass filter.
//
//   Transfer    Handshake                      Payload
//   item        item_valid / item_ready        sample_in, chan_sel
//   result      result_valid / result_ready    sample_out, chan_out
//   config      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// After acceptance the block captures the item, runs the single shared
// multiplier for the five taps and accumulates the last product, rounds,
// performs the gain multiply and commits; it is then ready for the next item.
// The result is valid the cycle after the commit.
// A result waiting in the output register does not stop the next item from
// being accepted; only the commit waits for the register to be free.
// Reset is synchronous and clears the coefficients to unity gain and all delay state.
`default_nettype none

module biquad_high_pass_filter #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [4:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic                          chan_sel,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  output logic                               chan_out
);
  import bhp_pkg::*;

  bhp_coef_t coef;
  bhp_cmd_t  cmd;
  logic      out_free;

  // Coefficient registers.
  bhp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  // Sequencer.
  bhp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .out_free   (out_free),
    .cmd        (cmd)
  );

  // Arithmetic and delay state.
  bhp_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .coef         (coef),
    .sample_in    (sample_in),
    .chan_sel     (chan_sel),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .sample_out   (sample_out),
    .chan_out     (chan_out),
    .out_free     (out_free)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bhp_checker.sv @@
// Port-level checks of the biquad high-pass filter, bound to its top level.
`default_nettype none

module bhp_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   pready,
  input wire logic                   item_valid,
  input wire logic                   item_ready,
  input wire logic                   result_valid,
  input wire logic                   result_ready,
  input wire logic [SAMPLE_BITS-1:0] sample_out,
  input wire logic                   chan_out
);

  // No result is offered straight after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered after reset");

  // A stalled result stays offered.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result withdrawn before transfer");

  // A stalled result keeps its payload.
  a_payload_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(sample_out) && $stable(chan_out))
    else $error("result payload changed while stalled");

  // One item at a time: the input closes after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready && pready)
    else $error("input still open after a transfer");

  // The result of an item cannot appear in the cycle after it was taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !$rose(result_valid))
    else $error("result appeared too early");

endmodule

bind biquad_high_pass_filter bhp_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bhp_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .sample_out   (sample_out),
  .chan_out     (chan_out)
);

`default_nettype wire
